[src/dmn_pkg.sv]
// Package for the distributed mutex node: message and result codes, widths,
// and the structs passed between the front end, the command queue and the back end.
// No dependencies.
package dmn_pkg;

  // Default number of node slots covered by the acknowledge mask.
  localparam int DMN_MAX_NODES = 8;

  // Node identifiers travel as three bits, so at most eight nodes can be named.
  localparam int NODE_ID_W   = 3;
  localparam int NODE_IDS    = 8;
  localparam int CLOCK_W     = 32;
  localparam int SECT_W      = 8;
  localparam int NCOUNT_W    = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

  // Incoming message and command codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;
  localparam logic [1:0] OP_REL   = 2'd3;

  // Outgoing result codes.
  localparam logic [1:0] KIND_BCAST = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_GRANT = 2'd2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Depth of the queue between front and back end.
  localparam int Q_DEPTH = 2;

  // One classified command, as held in the queue.
  typedef struct packed {
    logic [1:0]           op;
    logic [NODE_ID_W-1:0] src;
    logic [CLOCK_W-1:0]   mclk;
    logic [SECT_W-1:0]    sect;
  } cmd_t;

  // One outgoing result.
  typedef struct packed {
    logic [1:0]           kind;
    logic [NODE_ID_W-1:0] dest;
    logic [CLOCK_W-1:0]   stamp;
    logic [SECT_W-1:0]    sect;
    logic                 last;
  } result_t;

endpackage

[src/dmn_front.sv]
// Front end of the distributed mutex node: takes incoming transactions and
// discards messages from itself or from nodes beyond the mask, then queues the rest.
// Depends on dmn_pkg.
module dmn_front #(
  parameter int MAX_NODES = dmn_pkg::DMN_MAX_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dmn_pkg::cmd_t                 in_cmd,
  input  logic [dmn_pkg::NODE_ID_W-1:0] own_node,
  output logic                          push,
  output dmn_pkg::cmd_t                 push_cmd,
  input  logic                          q_full
);

  logic is_msg;
  logic src_in_range;
  logic from_self;
  logic keep;

  // Requests and acks from ourselves or from unknown nodes have no effect.
  always_comb begin
    is_msg       = (in_cmd.op == dmn_pkg::OP_REQ) || (in_cmd.op == dmn_pkg::OP_ACK);
    src_in_range = 32'(in_cmd.src) < 32'(MAX_NODES);
    from_self    = in_cmd.src == own_node;
    keep         = !is_msg || (src_in_range && !from_self);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;
  assign push_cmd = in_cmd;

  // The front end holds no state of its own; clock and reset are kept for symmetry.
  logic unused_clk_rst;
  assign unused_clk_rst = clk ^ rst;

endmodule

[src/dmn_queue.sv]
// Short command queue between the front end and the back end of the mutex node.
// Depends on dmn_pkg.
module dmn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dmn_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  output dmn_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int PTR_W = (dmn_pkg::Q_DEPTH > 1) ? $clog2(dmn_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(dmn_pkg::Q_DEPTH + 1);

  dmn_pkg::cmd_t entries [dmn_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(dmn_pkg::Q_DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = entries[rd_ptr];

  // Pointer wrap for any depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == dmn_pkg::Q_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  // Storage is written only on push; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/dmn_back.sv]
// Back end of the mutex node: Lamport clock, request state, ack and deferral
// masks, and the output register; walks the deferred mask on release.
// Depends on dmn_pkg.
module dmn_back #(
  parameter int MAX_NODES = dmn_pkg::DMN_MAX_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  dmn_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [dmn_pkg::NODE_ID_W-1:0] own_node,
  input  logic [dmn_pkg::NCOUNT_W-1:0]  node_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dmn_pkg::result_t              out_res
);

  // Sequencer states.
  localparam logic [1:0] S_CMD   = 2'd0;
  localparam logic [1:0] S_GRANT = 2'd1;
  localparam logic [1:0] S_REL   = 2'd2;

  // Protocol phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  localparam logic [dmn_pkg::CLOCK_W-1:0] CLK_MAX = '1;

  logic [1:0]                      state;
  logic [1:0]                      phase;
  logic [dmn_pkg::CLOCK_W-1:0]     lamport_clock;
  logic [dmn_pkg::CLOCK_W-1:0]     request_stamp;
  logic [dmn_pkg::SECT_W-1:0]      wanted_section;
  logic [MAX_NODES-1:0]            ack_mask;
  logic [dmn_pkg::NODE_IDS-1:0]    deferred_mask;

  logic                            out_free;
  logic [MAX_NODES-1:0]            need;
  logic [MAX_NODES-1:0]            own_bit;
  logic [MAX_NODES-1:0]            src_bit;
  logic [MAX_NODES-1:0]            ack_after;
  logic [dmn_pkg::CLOCK_W-1:0]     clk_max_in;
  logic                            same_sect;
  logic                            own_wins;
  logic                            defer;
  logic [dmn_pkg::NODE_ID_W-1:0]   rel_idx;
  logic [dmn_pkg::NODE_IDS-1:0]    rel_rest;

  function automatic logic [dmn_pkg::CLOCK_W-1:0] sat_inc(
    input logic [dmn_pkg::CLOCK_W-1:0] v
  );
    return (v == CLK_MAX) ? v : v + dmn_pkg::CLOCK_W'(1);
  endfunction

  // Two saturating increments folded into one add.
  function automatic logic [dmn_pkg::CLOCK_W-1:0] sat_inc2(
    input logic [dmn_pkg::CLOCK_W-1:0] v
  );
    return (v >= CLK_MAX - dmn_pkg::CLOCK_W'(1)) ? CLK_MAX : v + dmn_pkg::CLOCK_W'(2);
  endfunction

  // Required set is nodes below node_count, capped at the mask width.
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      need[i] = 32'(i) < 32'(node_count);
    end
  end

  // Mask bits and precedence test for the command at the head of the queue.
  always_comb begin
    own_bit    = MAX_NODES'(1) << own_node;
    src_bit    = MAX_NODES'(1) << cmd.src;
    ack_after  = ack_mask | src_bit;
    clk_max_in = (cmd.mclk > lamport_clock) ? cmd.mclk : lamport_clock;
    same_sect  = cmd.sect == wanted_section;
    own_wins   = (request_stamp < cmd.mclk) ||
                 ((request_stamp == cmd.mclk) && (own_node < cmd.src));
    defer      = ((phase == PH_HELD) && same_sect) ||
                 ((phase == PH_WAIT) && same_sect && own_wins);
  end

  // Lowest deferred node first.
  always_comb begin
    rel_idx = '0;
    for (int i = dmn_pkg::NODE_IDS - 1; i >= 0; i--) begin
      if (deferred_mask[i]) begin
        rel_idx = dmn_pkg::NODE_ID_W'(i);
      end
    end
    rel_rest = deferred_mask & ~(dmn_pkg::NODE_IDS'(1) << rel_idx);
  end

  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = (state == S_CMD) && cmd_valid && out_free;

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      case (cmd.op)
        dmn_pkg::OP_START: begin
          out_res <= '{kind: dmn_pkg::KIND_BCAST, dest: '0, stamp: lamport_clock,
                       sect: cmd.sect, last: (own_bit & need) != need};
        end
        dmn_pkg::OP_ACK: begin
          out_res <= '{kind: dmn_pkg::KIND_GRANT, dest: '0, stamp: '0,
                       sect: wanted_section, last: 1'b1};
        end
        default: begin
          out_res <= '{kind: dmn_pkg::KIND_ACK, dest: cmd.src, stamp: '0,
                       sect: '0, last: 1'b1};
        end
      endcase
    end else if (state == S_GRANT && out_free) begin
      out_res <= '{kind: dmn_pkg::KIND_GRANT, dest: '0, stamp: '0,
                   sect: wanted_section, last: 1'b1};
    end else if (state == S_REL && out_free) begin
      out_res <= '{kind: dmn_pkg::KIND_ACK, dest: rel_idx, stamp: '0,
                   sect: '0, last: rel_rest == '0};
    end
  end

  // Protocol state, clock and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CMD;
      phase          <= PH_IDLE;
      lamport_clock  <= '0;
      request_stamp  <= '0;
      wanted_section <= '0;
      ack_mask       <= '0;
      deferred_mask  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CMD: begin
          if (cmd_pop) begin
            case (cmd.op)
              dmn_pkg::OP_START: begin
                if (phase == PH_IDLE) begin
                  request_stamp  <= lamport_clock;
                  wanted_section <= cmd.sect;
                  ack_mask       <= own_bit;
                  phase          <= PH_WAIT;
                  lamport_clock  <= sat_inc(lamport_clock);
                  out_valid      <= 1'b1;
                  if ((own_bit & need) == need) begin
                    state <= S_GRANT;
                  end
                end
              end
              dmn_pkg::OP_REQ: begin
                if (defer) begin
                  deferred_mask <= deferred_mask | (dmn_pkg::NODE_IDS'(1) << cmd.src);
                  lamport_clock <= sat_inc(clk_max_in);
                end else begin
                  lamport_clock <= sat_inc2(clk_max_in);
                  out_valid     <= 1'b1;
                end
              end
              dmn_pkg::OP_ACK: begin
                if (phase == PH_WAIT) begin
                  ack_mask <= ack_after;
                  if ((ack_after & need) == need) begin
                    phase     <= PH_HELD;
                    out_valid <= 1'b1;
                  end
                end
              end
              default: begin
                if (phase == PH_HELD) begin
                  phase    <= PH_IDLE;
                  ack_mask <= '0;
                  if (deferred_mask != '0) begin
                    state <= S_REL;
                  end
                end
              end
            endcase
          end
        end
        S_GRANT: begin
          if (out_free) begin
            phase     <= PH_HELD;
            out_valid <= 1'b1;
            state     <= S_CMD;
          end
        end
        S_REL: begin
          if (out_free) begin
            deferred_mask <= rel_rest;
            lamport_clock <= sat_inc(lamport_clock);
            out_valid     <= 1'b1;
            if (rel_rest == '0) begin
              state <= S_CMD;
            end
          end
        end
        default: begin
          state <= S_CMD;
        end
      endcase
    end
  end

endmodule

[src/distributed_mutex_node.sv]
// Top level of one Ricart-Agrawala mutual exclusion node: stream ports,
// configuration registers, front end, command queue and back end.
// Depends on dmn_pkg, dmn_front, dmn_queue and dmn_back.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         tvalid / tready           tuser: opcode; tdata: message fields
//   m_axis    out        tvalid / tready / tlast   tuser: kind; tdata: result fields
//   cfg       in         cfg_we                    cfg_index, cfg_wdata
//
// An accepted transaction is written into a two-entry queue; the back end pops it
// from the queue head and registers its first result in the output register. The
// back end takes no new command in S_GRANT or while it walks the deferred mask after
// a release, which sends one ack per deferred node. Reset is synchronous; it clears
// the clock, masks, phase and queue, and sets own node to 0 and node count to 8.
// A stalled output holds the back end; the queue lets the input run two ahead.
module distributed_mutex_node #(
  parameter int MAX_NODES = dmn_pkg::DMN_MAX_NODES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] source_node, [34:3] msg_clock, [42:35] section_id, rest zero
  input  logic [dmn_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] dest_node, [34:3] stamp, [42:35] target_section, rest zero
  output logic [dmn_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [dmn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmn_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [dmn_pkg::NODE_ID_W-1:0] own_node;
  logic [dmn_pkg::NCOUNT_W-1:0]  node_count;
  dmn_pkg::cmd_t                 in_cmd;
  dmn_pkg::cmd_t                 push_cmd;
  dmn_pkg::cmd_t                 head_cmd;
  dmn_pkg::result_t              res;
  logic                          push;
  logic                          q_full;
  logic                          head_valid;
  logic                          pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node   <= '0;
      node_count <= dmn_pkg::NCOUNT_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        dmn_pkg::CFG_OWN_NODE:   own_node   <= cfg_wdata[dmn_pkg::NODE_ID_W-1:0];
        dmn_pkg::CFG_NODE_COUNT: node_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the incoming transaction.
  always_comb begin
    in_cmd.op   = s_axis_tuser;
    in_cmd.src  = s_axis_tdata[2:0];
    in_cmd.mclk = s_axis_tdata[34:3];
    in_cmd.sect = s_axis_tdata[42:35];
  end

  dmn_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (in_cmd),
    .own_node (own_node),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  dmn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (head_valid),
    .pop_cmd   (head_cmd),
    .pop       (pop)
  );

  dmn_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (pop),
    .own_node   (own_node),
    .node_count (node_count),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res)
  );

  // Pack the outgoing transaction.
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {5'b0, res.sect, res.stamp, res.dest};

endmodule
